@@ rtl/ilir_pkg.sv @@
// Shared types and codes for the indexed list store.
`timescale 1ns / 1ps
package ilir_pkg;

  localparam int FUNC_W = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_GET    = 2'd2;
  localparam logic [FUNC_W-1:0] FN_SET    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Command broadcast to every cell of the row
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_INS   = 2'd1;
  localparam logic [1:0] OP_REM   = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value_out;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  entry_count;
    logic [CNT_W-1:0]  capacity_now;
  } res_t;

endpackage

@@ rtl/ilir_in_if.sv @@
// Request channel: valid/ready handshake with the request payload.
`timescale 1ns / 1ps
interface ilir_in_if;
  logic                        valid;
  logic                        ready;
  logic [ilir_pkg::FUNC_W-1:0] func;
  logic [ilir_pkg::POS_W-1:0]  position;
  logic [ilir_pkg::VAL_W-1:0]  value_in;

  modport source (output valid, func, position, value_in, input ready);
  modport sink (input valid, func, position, value_in, output ready);
endinterface

@@ rtl/ilir_out_if.sv @@
// Result channel: valid/ready handshake with the result payload.
`timescale 1ns / 1ps
interface ilir_out_if;
  logic                        valid;
  logic                        ready;
  logic [ilir_pkg::VAL_W-1:0]  value_out;
  logic [ilir_pkg::STAT_W-1:0] status;
  logic [ilir_pkg::CNT_W-1:0]  entry_count;
  logic [ilir_pkg::CNT_W-1:0]  capacity_now;

  modport source (output valid, value_out, status, entry_count, capacity_now, input ready);
  modport sink (input valid, value_out, status, entry_count, capacity_now, output ready);
endinterface

@@ rtl/indexed_list_insert_remove.sv @@
// Latency: a result is valid the cycle after its item is accepted (one output register).
// Throughput: one item per cycle while results are taken; the whole cell row shifts
// in parallel in the accepting cycle, and the output register holds a waiting result.
// Input ready drops only while a result waits and the output side stalls.
// Reset: synchronous, active low; clears count to 0, capacity to 1 and the output
// valid flag. Entries above the count are never read and take no reset.
`timescale 1ns / 1ps
module indexed_list_insert_remove #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  ilir_in_if.sink       in_ch,
  ilir_out_if.source    out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [AW-1:0]         rd_idx;
  logic                  accept;
  ilir_pkg::cmd_t        cmd;
  ilir_pkg::res_t        res;
  logic                  out_valid_r;
  ilir_pkg::res_t        out_res_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign rd_idx  = AW'(in_ch.position);
  assign rd_data = (int'(in_ch.position) < DEPTH) ? cell_q[rd_idx] : '0;

  ilir_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .func     (in_ch.func),
    .position (in_ch.position),
    .value_in (in_ch.value_in),
    .rd_data  (rd_data),
    .cmd      (cmd),
    .wr_data  (wr_data),
    .res      (res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_q;
    logic [DATA_WIDTH-1:0] right_q;
    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_left
      assign left_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_right
      assign right_q = cell_q[i+1];
    end
    ilir_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .wr_data (wr_data),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.value_out    = out_res_r.value_out;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.entry_count  = out_res_r.entry_count;
  assign out_ch.capacity_now = out_res_r.capacity_now;

endmodule

@@ rtl/ilir_cell.sv @@
// One list entry; shifts to or from its neighbors on insert and remove.
`timescale 1ns / 1ps
module ilir_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  ilir_pkg::cmd_t        cmd,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] left_q,
  input  logic [DATA_WIDTH-1:0] right_q,
  output logic [DATA_WIDTH-1:0] q
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  at_pos;
  logic                  above_pos;

  assign at_pos    = (INDEX == int'(cmd.pos));
  assign above_pos = (INDEX > int'(cmd.pos));

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      ilir_pkg::OP_INS: begin
        if (at_pos) begin
          data_nxt = wr_data;
        end else if (above_pos) begin
          data_nxt = left_q;
        end
      end
      ilir_pkg::OP_REM: begin
        if (at_pos || above_pos) begin
          data_nxt = right_q;
        end
      end
      ilir_pkg::OP_WRITE: begin
        if (at_pos) begin
          data_nxt = wr_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // entries at or above the count are never read, so no reset is needed
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

@@ rtl/ilir_ctrl.sv @@
// Count and capacity bookkeeping, range checks and the command for the cell row.
`timescale 1ns / 1ps
module ilir_ctrl #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [ilir_pkg::FUNC_W-1:0] func,
  input  logic [ilir_pkg::POS_W-1:0]  position,
  input  logic [ilir_pkg::VAL_W-1:0]  value_in,
  input  logic [DATA_WIDTH-1:0]       rd_data,
  output ilir_pkg::cmd_t              cmd,
  output logic [DATA_WIDTH-1:0]       wr_data,
  output ilir_pkg::res_t              res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W;

  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 cap_r, cap_nxt;
  logic [CW-1:0]                 cnt_dec;
  logic [CW-1:0]                 cap_grown;
  logic [CW-1:0]                 cap_shrunk;
  logic [CW:0]                   cap_dbl;
  logic [PW-1:0]                 posx, cntx;
  logic                          do_ins;
  logic [ilir_pkg::STAT_W-1:0]   st;
  logic [DATA_WIDTH-1:0]         vout;

  assign posx    = PW'(position);
  assign cntx    = PW'(count_r);
  assign cnt_dec = count_r - CW'(1);
  assign cap_dbl = {cap_r, 1'b0};

  always_comb begin
    if (cap_dbl > (CW + 1)'(DEPTH)) begin
      cap_grown = CW'(DEPTH);
    end else begin
      cap_grown = cap_dbl[CW-1:0];
    end
  end

  // One removal drops at most one halving step unless the list empties
  always_comb begin
    if (cnt_dec == '0) begin
      cap_shrunk = CW'(1);
    end else if ({cnt_dec, 2'b00} < {2'b00, cap_r}) begin
      cap_shrunk = cap_r >> 1;
    end else begin
      cap_shrunk = cap_r;
    end
  end

  always_comb begin
    cmd.op    = ilir_pkg::OP_HOLD;
    cmd.pos   = position;
    wr_data   = DATA_WIDTH'(value_in);
    count_nxt = count_r;
    cap_nxt   = cap_r;
    do_ins    = 1'b0;
    st        = ilir_pkg::ST_OK;
    vout      = '0;
    unique case (func)
      ilir_pkg::FN_INSERT: begin
        if (posx > cntx) begin
          st = ilir_pkg::ST_RANGE;
        end else begin
          do_ins = 1'b1;
        end
      end
      ilir_pkg::FN_REMOVE: begin
        if (posx >= cntx) begin
          st = ilir_pkg::ST_RANGE;
        end else begin
          vout      = rd_data;
          cmd.op    = ilir_pkg::OP_REM;
          count_nxt = cnt_dec;
          cap_nxt   = cap_shrunk;
        end
      end
      ilir_pkg::FN_GET: begin
        if (posx >= cntx) begin
          st = ilir_pkg::ST_RANGE;
        end else begin
          vout = rd_data;
        end
      end
      ilir_pkg::FN_SET: begin
        if (posx > cntx) begin
          st = ilir_pkg::ST_RANGE;
        end else if (posx == cntx) begin
          do_ins = 1'b1;  // append at the end
        end else begin
          vout   = rd_data;
          cmd.op = ilir_pkg::OP_WRITE;
        end
      end
      default: st = ilir_pkg::ST_OK;
    endcase
    if (do_ins) begin
      if (count_r == CW'(DEPTH)) begin
        st = ilir_pkg::ST_FULL;
      end else begin
        cmd.op    = ilir_pkg::OP_INS;
        count_nxt = count_r + CW'(1);
        if (count_r == cap_r) begin
          cap_nxt = cap_grown;
        end
      end
    end
    if (!accept) begin
      cmd.op = ilir_pkg::OP_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CW'(1);
    end else if (accept) begin
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
    end
  end

  assign res.value_out    = ilir_pkg::VAL_W'(vout);
  assign res.status       = st;
  assign res.entry_count  = ilir_pkg::CNT_W'(count_nxt);
  assign res.capacity_now = ilir_pkg::CNT_W'(cap_nxt);

endmodule

@@ rtl/ilir_checker.sv @@
// Port-level checks for the indexed list store, bound to the top level.
`timescale 1ns / 1ps
module ilir_checker #(
  parameter int DEPTH = 64
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ilir_pkg::VAL_W-1:0]  value_out,
  input logic [ilir_pkg::STAT_W-1:0] status,
  input logic [ilir_pkg::CNT_W-1:0]  entry_count,
  input logic [ilir_pkg::CNT_W-1:0]  capacity_now
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(status)
      && $stable(entry_count) && $stable(capacity_now))
    else $error("stalled result changed");

  // requests are refused only while a result is stuck at the output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // failed requests return no data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ilir_pkg::ST_OK |-> value_out == '0)
    else $error("error result carries data");

  // full is reported only with every entry in use
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ilir_pkg::ST_FULL |-> entry_count == ilir_pkg::CNT_W'(DEPTH))
    else $error("full reported below depth");

  // an accepted item shows up as a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("result missing after accept");

endmodule

bind indexed_list_insert_remove ilir_checker #(
  .DEPTH (DEPTH)
) u_ilir_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .value_out    (out_ch.value_out),
  .status       (out_ch.status),
  .entry_count  (out_ch.entry_count),
  .capacity_now (out_ch.capacity_now)
);

@@ tb/sv/testbench.sv @@
// Self-checking bench for the indexed list store: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module testbench;

  localparam int DEPTH       = 64;
  localparam int N_RANDOM    = 650;
  localparam int QUIET_ITEMS = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  // Tracks list contents and predicts the result of every accepted request
  class list_scoreboard;
    logic [ilir_pkg::VAL_W-1:0] cells[DEPTH];
    int unsigned                count;
    int unsigned                cap;
    ilir_pkg::res_t             pending[$];
    int                         errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      foreach (cells[i]) cells[i] = '0;
      count = 0;
      cap   = 1;
      pending.delete();
    endfunction

    function logic [ilir_pkg::STAT_W-1:0] insert_at(int unsigned p,
                                                    logic [ilir_pkg::VAL_W-1:0] val);
      if (p > count) return ilir_pkg::ST_RANGE;
      if (count >= DEPTH) return ilir_pkg::ST_FULL;
      if (count == cap) begin
        cap = cap * 2;
        if (cap > DEPTH) cap = DEPTH;
      end
      for (int i = count; i > p; i--) cells[i] = cells[i-1];
      cells[p] = val;
      count++;
      return ilir_pkg::ST_OK;
    endfunction

    function void note_request(logic [ilir_pkg::FUNC_W-1:0] fn,
                               logic [ilir_pkg::POS_W-1:0] pos,
                               logic [ilir_pkg::VAL_W-1:0] val);
      ilir_pkg::res_t r;
      int unsigned    p;
      r = '0;
      p = pos;
      r.status = ilir_pkg::ST_OK;
      case (fn)
        ilir_pkg::FN_INSERT: r.status = insert_at(p, val);
        ilir_pkg::FN_REMOVE: begin
          if (p >= count) begin
            r.status = ilir_pkg::ST_RANGE;
          end else begin
            r.value_out = cells[p];
            count--;
            for (int i = p; i < count; i++) cells[i] = cells[i+1];
            cells[count] = '0;
            while (count * 4 < cap && cap > 1) cap = cap / 2;
          end
        end
        ilir_pkg::FN_GET: begin
          if (p >= count) r.status = ilir_pkg::ST_RANGE;
          else r.value_out = cells[p];
        end
        default: begin
          if (p > count) begin
            r.status = ilir_pkg::ST_RANGE;
          end else if (p == count) begin
            r.status = insert_at(p, val);
          end else begin
            r.value_out = cells[p];
            cells[p] = val;
          end
        end
      endcase
      r.entry_count  = count[ilir_pkg::CNT_W-1:0];
      r.capacity_now = cap[ilir_pkg::CNT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(ilir_pkg::res_t got);
      ilir_pkg::res_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h/%0d/%0d/%0d", $realtime,
                 got.value_out, got.status, got.entry_count, got.capacity_now);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.value_out !== want.value_out) begin
        $display("%0t value_out mismatch: expected %h actual %h", $realtime,
                 want.value_out, got.value_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t status mismatch: expected %0d actual %0d", $realtime,
                 want.status, got.status);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t entry_count mismatch: expected %0d actual %0d", $realtime,
                 want.entry_count, got.entry_count);
        errors++;
      end
      if (got.capacity_now !== want.capacity_now) begin
        $display("%0t capacity_now mismatch: expected %0d actual %0d", $realtime,
                 want.capacity_now, got.capacity_now);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles;
  bit   quiet;
  bit   hold_req;
  bit   hold_done;
  list_scoreboard sb = new();

  ilir_in_if  in_ch();
  ilir_out_if out_ch();

  indexed_list_insert_remove #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(ilir_pkg::VAL_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Monitor: values seen here are the ones present before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.value_out, out_ch.status, out_ch.entry_count,
                          out_ch.capacity_now});
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.func, in_ch.position, in_ch.value_in);
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Offer one item, with an optional idle burst first; returns at the accepting edge
  task automatic send_request(logic [ilir_pkg::FUNC_W-1:0] fn,
                              logic [ilir_pkg::POS_W-1:0] pos,
                              logic [ilir_pkg::VAL_W-1:0] val, bit may_idle);
    if (may_idle && !quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= fn;
    in_ch.position <= pos;
    in_ch.value_in <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Requests shaped by phase: filling, churning near full, draining, mixed
  task automatic pick_request(int idx, output logic [ilir_pkg::FUNC_W-1:0] fn,
                              output logic [ilir_pkg::POS_W-1:0] pos,
                              output logic [ilir_pkg::VAL_W-1:0] val);
    int          phase;
    int unsigned roll;
    int unsigned live;
    phase = (idx / 80) % 4;
    roll  = $urandom_range(0, 99);
    live  = sb.count;
    case (phase)
      0: fn = (roll < 75) ? ilir_pkg::FN_INSERT : 2'($urandom_range(0, 3));
      2: fn = (roll < 75) ? ilir_pkg::FN_REMOVE : 2'($urandom_range(0, 3));
      default: fn = 2'($urandom_range(0, 3));
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 80) pos = 7'($urandom_range(0, live));
    else if (roll < 90) pos = 7'(live);
    else pos = 7'($urandom_range(0, 127));
    roll = $urandom_range(0, 9);
    if (roll == 0) val = '0;
    else if (roll == 1) val = '1;
    else val = $urandom;
  endtask

  initial begin
    logic [ilir_pkg::FUNC_W-1:0] fn;
    logic [ilir_pkg::POS_W-1:0]  pos;
    logic [ilir_pkg::VAL_W-1:0]  val;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = ilir_pkg::FN_GET;
    in_ch.position = '0;
    in_ch.value_in = '0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: every access is out of range
    send_request(ilir_pkg::FN_GET,    7'd0,   32'h0, 1'b1);
    send_request(ilir_pkg::FN_REMOVE, 7'd0,   32'h0, 1'b1);
    send_request(ilir_pkg::FN_SET,    7'd1,   32'h1, 1'b1);
    send_request(ilir_pkg::FN_INSERT, 7'd1,   32'h1, 1'b1);
    // Appending set, then growth through capacity 2, 4, 8
    send_request(ilir_pkg::FN_SET,    7'd0,   32'hFFFF_FFFF, 1'b1);
    send_request(ilir_pkg::FN_INSERT, 7'd0,   32'h0000_0000, 1'b1);
    send_request(ilir_pkg::FN_INSERT, 7'd2,   32'hA5A5_A5A5, 1'b1);
    send_request(ilir_pkg::FN_INSERT, 7'd1,   32'h5A5A_5A5A, 1'b1);
    send_request(ilir_pkg::FN_GET,    7'd0,   32'h0, 1'b1);
    send_request(ilir_pkg::FN_GET,    7'd3,   32'h0, 1'b1);
    send_request(ilir_pkg::FN_GET,    7'd4,   32'h0, 1'b1);
    send_request(ilir_pkg::FN_SET,    7'd4,   32'h1234_5678, 1'b1);
    send_request(ilir_pkg::FN_SET,    7'd2,   32'h8765_4321, 1'b1);
    // Far positions, top bit of the index set
    send_request(ilir_pkg::FN_INSERT, 7'd127, 32'hFFFF_FFFF, 1'b1);
    send_request(ilir_pkg::FN_GET,    7'd127, 32'h0, 1'b1);
    send_request(ilir_pkg::FN_REMOVE, 7'd64,  32'h0, 1'b1);
    send_request(ilir_pkg::FN_SET,    7'd127, 32'h0, 1'b1);
    // Drain: removal at the end, at the front, then shrink back to capacity 1
    send_request(ilir_pkg::FN_REMOVE, 7'd4,   32'h0, 1'b1);
    send_request(ilir_pkg::FN_REMOVE, 7'd0,   32'h0, 1'b1);
    send_request(ilir_pkg::FN_REMOVE, 7'd1,   32'h0, 1'b1);
    send_request(ilir_pkg::FN_REMOVE, 7'd0,   32'h0, 1'b1);
    send_request(ilir_pkg::FN_REMOVE, 7'd0,   32'h0, 1'b1);
    send_request(ilir_pkg::FN_REMOVE, 7'd0,   32'h0, 1'b1);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_req = 1'b1;
      if (i == N_RANDOM - QUIET_ITEMS) quiet = 1'b1;
      pick_request(i, fn, pos, val);
      // phase three runs back to back
      send_request(fn, pos, val, ((i / 80) % 4) != 3 && !(hold_req && !hold_done));
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ilir_pkg.sv
rtl/ilir_in_if.sv
rtl/ilir_out_if.sv
rtl/ilir_cell.sv
rtl/ilir_ctrl.sv
rtl/indexed_list_insert_remove.sv
rtl/ilir_checker.sv
tb/sv/testbench.sv
